// ===== hdl/ros_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ros_pkg
// Shared sizes, types and command codes for the running order statistics
// block: sorted cell chain, median read tree and mean divider.
// ----------------------------------------------------------------------------
package ros_pkg;

	// store size and derived widths
	localparam int DEPTH   = 1024;
	localparam int SMP_W   = 32;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = SMP_W + IDX_W;
	localparam int STEP_W  = $clog2(SUM_W + 1);

	// median read tree: groups of GRP cells, then one pick among the groups
	localparam int GRP     = 32;
	localparam int LSEL_W  = $clog2(GRP);
	localparam int GRP_CNT = (DEPTH + GRP - 1) / GRP;
	localparam int GSEL_W  = (GRP_CNT > 1) ? $clog2(GRP_CNT) : 1;
	localparam int SEL_W   = LSEL_W + GSEL_W;

	// request commands
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic        [CNT_W-1:0] cnt_t;
	typedef logic        [SEL_W-1:0] sel_t;

	// divider launch
	typedef struct packed {
		logic start;
		sum_t dividend;
		cnt_t divisor;
	} div_req_t;

endpackage
`default_nettype wire

// ===== hdl/ros_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ros_req_if
// Request channel: command and sample with valid/ready.
// ----------------------------------------------------------------------------
interface ros_req_if;
	import ros_pkg::*;

	logic valid;
	logic ready;
	logic command;
	smp_t sample;

	modport source (output valid, output command, output sample, input ready);
	modport sink   (input valid, input command, input sample, output ready);

endinterface
`default_nettype wire

// ===== hdl/ros_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ros_rsp_if
// Result channel: count, min, max, median, mean and drop flag.
// ----------------------------------------------------------------------------
interface ros_rsp_if;
	import ros_pkg::*;

	logic valid;
	logic ready;
	cnt_t count;
	smp_t smallest;
	smp_t largest;
	smp_t middle;
	smp_t average;
	logic dropped;

	modport source (output valid, output count, output smallest, output largest,
		output middle, output average, output dropped, input ready);
	modport sink   (input valid, input count, input smallest, input largest,
		input middle, input average, input dropped, output ready);

endinterface
`default_nettype wire

// ===== hdl/ros_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ros_cell
// One entry of the sorted chain. On insert, an entry greater than the new
// sample moves up one place; the first such entry takes the sample itself.
// ----------------------------------------------------------------------------
module ros_cell (
	input  wire            clk,
	input  wire            load,
	input  ros_pkg::smp_t  x,
	input  wire            occ,
	input  ros_pkg::smp_t  prev_val,
	input  wire            prev_gt,
	output ros_pkg::smp_t  val,
	output logic           gt
);
	import ros_pkg::*;

	smp_t val_q;

	// free or holding a larger value: this place moves
	assign gt  = !occ || (val_q > x);
	assign val = val_q;

	// take the neighbor's value, or the sample at the insert point
	always_ff @(posedge clk) begin
		if (load && gt) begin
			val_q <= prev_gt ? prev_val : x;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ros_sel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ros_sel
// Two-stage registered read of two chain entries: pick within each group of
// cells, then pick the group.
// ----------------------------------------------------------------------------
module ros_sel (
	input  wire            clk,
	input  ros_pkg::smp_t  vals [ros_pkg::GRP_CNT][ros_pkg::GRP],
	input  ros_pkg::sel_t  idx_a,
	input  ros_pkg::sel_t  idx_b,
	output ros_pkg::smp_t  a_s2,
	output ros_pkg::smp_t  b_s2
);
	import ros_pkg::*;

	smp_t              grp_a_s1 [GRP_CNT];
	smp_t              grp_b_s1 [GRP_CNT];
	logic [GSEL_W-1:0] gsel_a_s1;
	logic [GSEL_W-1:0] gsel_b_s1;
	smp_t              a_q;
	smp_t              b_q;

	// pick within each group
	always_ff @(posedge clk) begin
		for (int g = 0; g < GRP_CNT; g++) begin
			grp_a_s1[g] <= vals[g][idx_a[LSEL_W-1:0]];
			grp_b_s1[g] <= vals[g][idx_b[LSEL_W-1:0]];
		end
		gsel_a_s1 <= idx_a[SEL_W-1:LSEL_W];
		gsel_b_s1 <= idx_b[SEL_W-1:LSEL_W];
	end

	// pick the group
	always_ff @(posedge clk) begin
		a_q <= grp_a_s1[gsel_a_s1];
		b_q <= grp_b_s1[gsel_b_s1];
	end

	assign a_s2 = a_q;
	assign b_s2 = b_q;

endmodule
`default_nettype wire

// ===== hdl/ros_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ros_div
// Bit-serial restoring divider for the mean: signed sum over unsigned count,
// truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ros_div (
	input  wire                clk,
	input  wire                arst_n,
	input  ros_pkg::div_req_t  req,
	output logic               busy,
	output ros_pkg::smp_t      quo
);
	import ros_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	cnt_t              rem_q;
	cnt_t              den_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;
	logic [SUM_W-1:0]  res;

	// one restoring step
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath: load magnitude, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend < 0;
			quo_q <= (req.dividend < 0) ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	// restore the sign
	assign res  = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
	assign quo  = res[SMP_W-1:0];
	assign busy = busy_q;

endmodule
`default_nettype wire

// ===== hdl/running_order_statistics_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// running_order_statistics_top
// Running count, minimum, maximum, median and mean of signed Q16.16 samples
// held in a sorted chain of cells.
// ----------------------------------------------------------------------------
//  port  | role   | payload
//  ------+--------+------------------------------------------------------
//  req   | sink   | command (add / clear), sample
//  rsp   | source | count, smallest, largest, middle, average, dropped
//
// In each request the cell chain inserts in the accept cycle, the median read
// tree is read in states ST_RD1 and ST_RD2, and the bit-serial mean divider
// sets the mean at one bit per cycle.
// One request is in work at a time; req.ready is high while idle, even when
// the previous result still waits in the output register. A stalled rsp
// holds the block before the next result is written. Reset empties the store.
// ----------------------------------------------------------------------------
module running_order_statistics_top (
	input  wire     clk,
	input  wire     arst_n,
	ros_req_if.sink   req,
	ros_rsp_if.source rsp
);
	import ros_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD1  = 3'd1;
	localparam logic [2:0] ST_RD2  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	cnt_t       cnt_q;
	sum_t       sum_q;
	smp_t       lg_q;
	logic       drop_q;

	logic       accept;
	logic       full;
	logic       load;

	smp_t       val_f [DEPTH];
	logic       gt_f  [DEPTH];
	logic       occ   [DEPTH];
	smp_t       grid  [GRP_CNT][GRP];

	cnt_t       half;
	sel_t       idx_a;
	sel_t       idx_b;
	smp_t       med_a;
	smp_t       med_b;
	logic [SMP_W:0] pair_sum;
	smp_t       mid;

	div_req_t   dreq;
	logic       div_busy;
	smp_t       div_quo;

	logic       rsp_valid_q;
	cnt_t       rsp_count_q;
	smp_t       rsp_smallest_q;
	smp_t       rsp_largest_q;
	smp_t       rsp_middle_q;
	smp_t       rsp_average_q;
	logic       rsp_dropped_q;
	logic       out_free;
	logic       empty;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign load      = accept && (req.command == CMD_ADD) && !full;

	// sorted cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < cnt_q);
		if (i == 0) begin : g_head
			ros_cell u_cell (
				.clk      (clk),
				.load     (load),
				.x        (req.sample),
				.occ      (occ[i]),
				.prev_val ('0),
				.prev_gt  (1'b0),
				.val      (val_f[i]),
				.gt       (gt_f[i])
			);
		end else begin : g_body
			ros_cell u_cell (
				.clk      (clk),
				.load     (load),
				.x        (req.sample),
				.occ      (occ[i]),
				.prev_val (val_f[i-1]),
				.prev_gt  (gt_f[i-1]),
				.val      (val_f[i]),
				.gt       (gt_f[i])
			);
		end
	end

	// arrange cells into read groups, pad the last group
	for (genvar i = 0; i < GRP_CNT * GRP; i++) begin : g_grid
		if (i < DEPTH) begin : g_used
			assign grid[i / GRP][i % GRP] = val_f[i];
		end else begin : g_pad
			assign grid[i / GRP][i % GRP] = '0;
		end
	end

	// median entries: h-1 and h for even counts, h for odd
	assign half  = cnt_q >> 1;
	assign idx_b = SEL_W'(half);
	assign idx_a = cnt_q[0] ? SEL_W'(half) : SEL_W'(half - CNT_W'(1));

	ros_sel u_sel (
		.clk   (clk),
		.vals  (grid),
		.idx_a (idx_a),
		.idx_b (idx_b),
		.a_s2  (med_a),
		.b_s2  (med_b)
	);

	// floor average of the middle pair
	assign pair_sum = {med_a[SMP_W-1], med_a} + {med_b[SMP_W-1], med_b};
	assign mid      = cnt_q[0] ? med_b : pair_sum[SMP_W:1];

	// mean
	assign dreq.start    = (state_q == ST_RD1);
	assign dreq.dividend = sum_q;
	assign dreq.divisor  = cnt_q;

	ros_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD1;
						drop_q  <= 1'b0;
						if (req.command == CMD_CLEAR) begin
							cnt_q <= '0;
							sum_q <= '0;
						end else if (full) begin
							drop_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
							sum_q <= sum_q + SUM_W'(req.sample);
						end
					end
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_DIV;
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// track the maximum over held samples
	always_ff @(posedge clk) begin
		if (load && ((cnt_q == '0) || (req.sample > lg_q))) begin
			lg_q <= req.sample;
		end
	end

	// output register
	assign out_free = !rsp_valid_q || rsp.ready;
	assign empty    = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			rsp_count_q    <= cnt_q;
			rsp_smallest_q <= empty ? '0 : val_f[0];
			rsp_largest_q  <= empty ? '0 : lg_q;
			rsp_middle_q   <= empty ? '0 : mid;
			rsp_average_q  <= empty ? '0 : div_quo;
			rsp_dropped_q  <= drop_q;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.count    = rsp_count_q;
	assign rsp.smallest = rsp_smallest_q;
	assign rsp.largest  = rsp_largest_q;
	assign rsp.middle   = rsp_middle_q;
	assign rsp.average  = rsp_average_q;
	assign rsp.dropped  = rsp_dropped_q;

endmodule
`default_nettype wire
